// ===== design/sso_pkg.sv =====
package sso_pkg;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_RESET  = 2'd2;

   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_BASE  = 2'd1;
   localparam logic [1:0] REG_GAIN  = 2'd2;

   localparam logic [31:0] WHEEL_BASE_RESET = 32'd66847;
   localparam logic [31:0] SPEED_GAIN_RESET = 32'd919982;

   localparam logic signed [63:0] Q_PI      = 64'sd205887;
   localparam logic signed [63:0] Q_TWO_PI  = 64'sd411775;
   localparam logic signed [63:0] Q_HALF_PI = 64'sd102944;
   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

   function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
      logic signed [33:0] v;
      case (i)
         5'd0:  v = 34'sd843314856;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043836;
         5'd3:  v = 34'sd133525158;
         5'd4:  v = 34'sd67021686;
         5'd5:  v = 34'sd33543515;
         5'd6:  v = 34'sd16775850;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194282;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048575;
         5'd11: v = 34'sd524287;
         5'd12: v = 34'sd262143;
         5'd13: v = 34'sd131071;
         5'd14: v = 34'sd65535;
         5'd15: v = 34'sd32767;
         5'd16: v = 34'sd16383;
         5'd17: v = 34'sd8191;
         5'd18: v = 34'sd4095;
         5'd19: v = 34'sd2047;
         5'd20: v = 34'sd1023;
         5'd21: v = 34'sd511;
         5'd22: v = 34'sd255;
         5'd23: v = 34'sd127;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== design/skid_steer_odometry_top.sv =====
// Skid-steer odometry, one item at a time through a shared multiplier,
// an angle reducer, a CORDIC rotator and a restoring divider.
// A wheel sample passes position updates, a turn step, angle reduction, CORDIC
// rotation, velocity and wheel speed steps, the divider (skipped with a zero wheel
// base) and a final step before rsp_valid rises; pose items raise it the cycle after
// accept. ready is low while an item is in work, until its response is taken.
// Reset (synchronous, active high) clears the pose, rates and registers to defaults.
module skid_steer_odometry_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_rpm_rear_left,
   input  logic signed [31:0] req_rpm_rear_right,
   input  logic signed [31:0] req_rpm_front_left,
   input  logic signed [31:0] req_rpm_front_right,
   input  logic [31:0]        req_stamp,
   input  logic signed [31:0] req_set_x,
   input  logic signed [31:0] req_set_y,
   input  logic signed [31:0] req_set_heading,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_heading,
   output logic signed [31:0] rsp_out_vel_x,
   output logic signed [31:0] rsp_out_vel_y,
   output logic signed [31:0] rsp_out_turn_rate,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam int CW = $clog2(STEPS + 1);
   localparam int MOD_STEPS = 30;
   localparam logic [47:0] MOD_TOP = 48'(sso_pkg::Q_TWO_PI <<< 29);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_POSX  = 4'd1;
   localparam logic [3:0] S_POSY  = 4'd2;
   localparam logic [3:0] S_WDT   = 4'd3;
   localparam logic [3:0] S_RED   = 4'd4;
   localparam logic [3:0] S_CORD  = 4'd5;
   localparam logic [3:0] S_VX    = 4'd6;
   localparam logic [3:0] S_VY    = 4'd7;
   localparam logic [3:0] S_VR    = 4'd8;
   localparam logic [3:0] S_VL    = 4'd9;
   localparam logic [3:0] S_RATE  = 4'd10;
   localparam logic [3:0] S_DIV   = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;
   localparam logic [3:0] S_OUT   = 4'd13;
   localparam logic [3:0] S_MOD   = 4'd14;

   logic [3:0] state_ff, state_in;
   logic mode_ff;
   logic [31:0] base_ff, gain_ff;
   logic signed [31:0] px_ff, py_ff, hd_ff, lin_ff, tr_ff, vx_ff, vy_ff;
   logic [31:0] last_ff, dt_ff;
   logic signed [32:0] lsum_ff, rsum_ff;
   logic signed [63:0] wdt_ff;
   logic [47:0] amag_ff, msub_ff;
   logic aneg_ff;
   logic [4:0] mcnt_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic flip_ff;
   logic [CW-1:0] cnt_ff;
   logic [5:0] dcnt_ff;
   logic signed [31:0] vr_ff, vl_ff;
   logic [48:0] num_ff;
   logic [32:0] rem_ff;
   logic dneg_ff;
   logic [31:0] q_out_ff;

   // Shared multiplier: signed 33 x unsigned 33 magnitude form.
   logic [32:0] mul_a, mul_b;
   logic [65:0] mul_p;
   assign mul_p = mul_a * mul_b;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

   logic signed [32:0] src;
   logic src_neg;
   logic signed [63:0] rnd16;
   logic signed [63:0] cord_v;
   logic signed [63:0] q30;

   always_comb begin
      mul_a = '0;
      mul_b = {1'b0, dt_ff};
      src = '0;
      case (state_ff)
         S_POSX: src = 33'(vx_ff);
         S_POSY: src = 33'(vy_ff);
         S_WDT:  src = 33'(tr_ff);
         S_VX:   src = 33'(lin_ff);
         S_VY:   src = 33'(lin_ff);
         S_VR:   src = rsum_ff;
         S_VL:   src = lsum_ff;
         default: src = '0;
      endcase
      mul_a = mag33(src);
      cord_v = flip_ff ? -64'(cy_ff) : 64'(cy_ff);
      if (state_ff == S_VX) cord_v = flip_ff ? -64'(cx_ff) : 64'(cx_ff);
      case (state_ff)
         S_VX, S_VY: mul_b = cord_v[63] ? 33'(-cord_v) : 33'(cord_v);
         S_VR, S_VL: mul_b = {1'b0, gain_ff};
         default: mul_b = {1'b0, dt_ff};
      endcase
      src_neg = src[32];
      rnd16 = 64'((mul_p + 66'h8000) >> 16);
      if (src_neg) rnd16 = -rnd16;
      // Q30 product keeps sign and floors after adding half.
      q30 = 64'(mul_p);
      if (src_neg != cord_v[63]) q30 = -q30;
      q30 = (q30 + 64'sd536870912) >>> 30;
   end

   logic signed [63:0] red;
   logic signed [63:0] r_mod;
   logic red_flip;
   logic signed [63:0] scl;
   logic signed [63:0] dx, dy;
   logic [32:0] rem_sh;
   logic signed [63:0] diff;
   logic signed [63:0] ang_v;

   always_comb begin
      ang_v = mode_ff ? 64'(hd_ff) + rnd16 / 2 : 64'(hd_ff);
      r_mod = aneg_ff ? -64'(amag_ff) : 64'(amag_ff);
      red = r_mod;
      red_flip = 1'b0;
      if (red >= sso_pkg::Q_PI) red = red - sso_pkg::Q_TWO_PI;
      if (red < -sso_pkg::Q_PI) red = red + sso_pkg::Q_TWO_PI;
      if (red > sso_pkg::Q_HALF_PI) begin
         red = red - sso_pkg::Q_PI;
         red_flip = 1'b1;
      end else if (red < -sso_pkg::Q_HALF_PI) begin
         red = red + sso_pkg::Q_PI;
         red_flip = 1'b1;
      end
      dx = 64'(cy_ff) >>> cnt_ff;
      dy = 64'(cx_ff) >>> cnt_ff;
      scl = 64'((mul_p + 66'h80000000) >> 32);
      if (src_neg != (state_ff == S_VL)) scl = -scl;
      rem_sh = {rem_ff[31:0], num_ff[48]};
      diff = 64'(vr_ff) - 64'(vl_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = (req_op == sso_pkg::OP_SAMPLE) ? S_POSX : S_OUT;
         S_POSX: state_in = S_POSY;
         S_POSY: state_in = S_WDT;
         S_WDT:  state_in = S_MOD;
         S_MOD:  if (mcnt_ff == 5'(MOD_STEPS - 1)) state_in = S_RED;
         S_RED:  state_in = S_CORD;
         S_CORD: if (32'(cnt_ff) == STEPS - 1 || STEPS == 0) state_in = S_VX;
         S_VX:   state_in = S_VY;
         S_VY:   state_in = S_VR;
         S_VR:   state_in = S_VL;
         S_VL:   state_in = S_RATE;
         S_RATE: state_in = (base_ff == '0) ? S_DONE : S_DIV;
         S_DIV:  if (dcnt_ff == 6'd48) state_in = S_DONE;
         S_DONE: state_in = S_OUT;
         S_OUT:  if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= 1'b0;
         base_ff <= sso_pkg::WHEEL_BASE_RESET;
         gain_ff <= sso_pkg::SPEED_GAIN_RESET;
         px_ff <= '0; py_ff <= '0; hd_ff <= '0; lin_ff <= '0;
         tr_ff <= '0; vx_ff <= '0; vy_ff <= '0; last_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sso_pkg::REG_MODE: mode_ff <= csr_data[0];
               sso_pkg::REG_BASE: base_ff <= csr_data;
               sso_pkg::REG_GAIN: gain_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (req_valid) begin
               lsum_ff <= 33'(req_rpm_rear_left) + 33'(req_rpm_front_left);
               rsum_ff <= 33'(req_rpm_rear_right) + 33'(req_rpm_front_right);
               dt_ff <= req_stamp - last_ff;
               if (req_op == sso_pkg::OP_SAMPLE) last_ff <= req_stamp;
               if (req_op == sso_pkg::OP_SET) begin
                  px_ff <= req_set_x; py_ff <= req_set_y; hd_ff <= req_set_heading;
               end else if (req_op == sso_pkg::OP_RESET) begin
                  px_ff <= '0; py_ff <= '0; hd_ff <= '0;
               end
            end
            S_POSX: px_ff <= sso_pkg::sat32(64'(px_ff) + rnd16);
            S_POSY: py_ff <= sso_pkg::sat32(64'(py_ff) + rnd16);
            S_WDT: begin
               wdt_ff <= rnd16;
               aneg_ff <= ang_v[63];
               amag_ff <= ang_v[63] ? 48'(-ang_v) : 48'(ang_v);
               msub_ff <= MOD_TOP;
               mcnt_ff <= '0;
            end
            S_MOD: begin
               // Each cycle the angle magnitude loses the shifted multiple of two pi if it is not smaller.
               if (amag_ff >= msub_ff) amag_ff <= amag_ff - msub_ff;
               msub_ff <= msub_ff >> 1;
               mcnt_ff <= mcnt_ff + 1'b1;
            end
            S_RED: begin
               cz_ff <= 34'(red * 64'sd16384);
               cx_ff <= sso_pkg::CORDIC_START;
               cy_ff <= '0;
               flip_ff <= red_flip;
               cnt_ff <= '0;
            end
            S_CORD: if (STEPS > 0) begin
               if (!cz_ff[33]) begin
                  cx_ff <= 34'(64'(cx_ff) - dx);
                  cy_ff <= 34'(64'(cy_ff) + dy);
                  cz_ff <= cz_ff - sso_pkg::atan_entry(5'(cnt_ff));
               end else begin
                  cx_ff <= 34'(64'(cx_ff) + dx);
                  cy_ff <= 34'(64'(cy_ff) - dy);
                  cz_ff <= cz_ff + sso_pkg::atan_entry(5'(cnt_ff));
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
            S_VX: vx_ff <= sso_pkg::sat32(q30);
            S_VY: begin
               vy_ff <= sso_pkg::sat32(q30);
               hd_ff <= sso_pkg::sat32(64'(hd_ff) + wdt_ff);
            end
            S_VR: vr_ff <= sso_pkg::sat32(scl);
            S_VL: vl_ff <= sso_pkg::sat32(scl);
            S_RATE: begin
               lin_ff <= 32'((64'(vr_ff) + 64'(vl_ff)) / 2);
               dneg_ff <= diff[63];
               num_ff <= {(diff[63] ? 33'(-diff) : 33'(diff)), 16'd0};
               rem_ff <= '0;
               dcnt_ff <= '0;
               if (base_ff == '0)
                  q_out_ff <= (diff > 0) ? 32'h7fffffff : ((diff < 0) ? 32'h80000000 : 32'h0);
            end
            S_DIV: begin
               // Restoring divider, one quotient bit a cycle into num_ff.
               if (rem_sh >= {1'b0, base_ff}) begin
                  rem_ff <= rem_sh - {1'b0, base_ff};
                  num_ff <= {num_ff[47:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  num_ff <= {num_ff[47:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
            end
            S_DONE: begin
               if (base_ff == '0) tr_ff <= q_out_ff;
               else tr_ff <= sso_pkg::sat32(dneg_ff ? -64'(num_ff) : 64'(num_ff));
            end
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_out_x = px_ff;
   assign rsp_out_y = py_ff;
   assign rsp_out_heading = hd_ff;
   assign rsp_out_vel_x = vx_ff;
   assign rsp_out_vel_y = vy_ff;
   assign rsp_out_turn_rate = tr_ff;

endmodule
